FILE: hw/rtl/grid_cell_range_enumerator_top_defines.svh
// Assertion macros for the enumerator RTL, used by gcre_scan
`ifndef GRID_CELL_RANGE_ENUMERATOR_TOP_DEFINES_SVH
`define GRID_CELL_RANGE_ENUMERATOR_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define GCRE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcre assertion failed");

// antecedent implies consequent in the next cycle
`define GCRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcre assertion failed");

`endif

FILE: hw/rtl/gcre_pkg.sv
package gcre_pkg;

  localparam int MAX_CELLS  = 64;
  localparam int CNT_W      = $clog2(MAX_CELLS + 1);
  localparam int SAT_W      = $clog2(MAX_CELLS + 2);
  localparam int COORD_W    = 24;
  localparam int QUOT_W     = COORD_W + 1;
  localparam int SIZE_W     = 15;
  localparam int BOUND_W    = 16;
  localparam int GRID_W     = 3 * BOUND_W;
  localparam int CELL_W     = BOUND_W + 2;
  localparam int DIM_W      = CELL_W + 1;
  localparam int IDX_W      = 32;
  localparam int DIV_CNT_W  = $clog2(COORD_W);
  localparam int CFG_ADDR_W = 3;
  localparam int PROD2_W    = 2 * SAT_W;
  localparam int PROD3_W    = 3 * SAT_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CELL_SIZE    = 3'd0,
    CFG_GRID_LOW     = 3'd1,
    CFG_GRID_HIGH    = 3'd2,
    CFG_ROW_STRIDE   = 3'd3,
    CFG_PLANE_STRIDE = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_low_x;
    logic signed [COORD_W-1:0] box_low_y;
    logic signed [COORD_W-1:0] box_low_z;
    logic signed [COORD_W-1:0] box_high_x;
    logic signed [COORD_W-1:0] box_high_y;
    logic signed [COORD_W-1:0] box_high_z;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] cell_index;
    logic             range_empty;
    logic             truncated;
    logic             last;
  } out_t;

  typedef struct packed {
    logic                     single;
    logic                     empty;
    logic                     trunc;
    logic signed [CELL_W-1:0] fx;
    logic signed [CELL_W-1:0] fy;
    logic signed [CELL_W-1:0] fz;
    logic signed [CELL_W-1:0] sx;
    logic signed [CELL_W-1:0] sy;
    logic signed [CELL_W-1:0] sz;
    logic [IDX_W-1:0]         base;
  } scan_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DLOAD,
    ST_DWAIT,
    ST_CHECK,
    ST_MUL,
    ST_LAUNCH,
    ST_WAIT
  } top_st_t;

  typedef enum logic {
    SC_IDLE,
    SC_RUN
  } sc_st_t;

endpackage

FILE: hw/rtl/gcre_div.sv
module gcre_div
  import gcre_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COORD_W-1:0] dividend,
  input  logic [SIZE_W-1:0]  divisor,
  output logic               done,
  output logic [COORD_W-1:0] quotient
);

  logic                 active_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [COORD_W-1:0]   q_r;
  logic [SIZE_W-1:0]    rem_r;
  logic [SIZE_W:0]      rem_sh;
  logic [SIZE_W:0]      rem_diff;
  logic                 q_bit;

  // one restoring step per cycle
  always_comb begin
    rem_sh   = {rem_r, q_r[COORD_W-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    q_bit    = (rem_sh >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(COORD_W - 1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (active_r) begin
      q_r   <= {q_r[COORD_W-2:0], q_bit};
      rem_r <= q_bit ? rem_diff[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: hw/rtl/gcre_scan.sv
`include "grid_cell_range_enumerator_top_defines.svh"

module gcre_scan
  import gcre_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  scan_cmd_t         cmd,
  input  logic [SIZE_W-1:0] row_stride,
  input  logic [SIZE_W-1:0] plane_stride,
  output logic              busy,
  output logic              out_valid,
  output out_t              out_data,
  input  logic              out_stall
);

  sc_st_t                   state_r;
  sc_st_t                   state_nxt;
  scan_cmd_t                cmd_r;
  logic signed [CELL_W-1:0] x_r;
  logic signed [CELL_W-1:0] y_r;
  logic signed [CELL_W-1:0] z_r;
  logic [IDX_W-1:0]         idx_r;
  logic [IDX_W-1:0]         line_r;
  logic [IDX_W-1:0]         plane_r;
  logic [CNT_W-1:0]         n_r;
  logic                     out_valid_r;
  out_t                     out_data_r;
  logic                     emit;
  logic                     at_end;
  logic                     cap;
  logic                     last_c;
  out_t                     res;
  logic [IDX_W-1:0]         line_step;
  logic [IDX_W-1:0]         plane_step;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SC_IDLE: if (start) state_nxt = SC_RUN;
      SC_RUN:  if (emit && last_c) state_nxt = SC_IDLE;
      default: state_nxt = SC_IDLE;
    endcase
  end

  always_comb begin
    emit       = (state_r == SC_RUN) && (!out_valid_r || !out_stall);
    at_end     = (x_r == cmd_r.sx) && (y_r == cmd_r.sy) && (z_r == cmd_r.sz);
    cap        = (n_r == CNT_W'(MAX_CELLS - 1));
    last_c     = cmd_r.single || at_end || cap;
    line_step  = line_r + IDX_W'(row_stride);
    plane_step = plane_r + IDX_W'(plane_stride);
    res.cell_index  = cmd_r.single ? '0 : idx_r;
    res.range_empty = cmd_r.single && cmd_r.empty;
    res.truncated   = !cmd_r.single && cmd_r.trunc;
    res.last        = last_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SC_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // x fastest, then y, then z
  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r   <= cmd;
      x_r     <= cmd.fx;
      y_r     <= cmd.fy;
      z_r     <= cmd.fz;
      idx_r   <= cmd.base;
      line_r  <= cmd.base;
      plane_r <= cmd.base;
      n_r     <= '0;
    end else if (emit) begin
      out_data_r <= res;
      n_r        <= n_r + 1'b1;
      if (x_r != cmd_r.sx) begin
        x_r   <= x_r + 1'b1;
        idx_r <= idx_r + 1'b1;
      end else if (y_r != cmd_r.sy) begin
        x_r    <= cmd_r.fx;
        y_r    <= y_r + 1'b1;
        line_r <= line_step;
        idx_r  <= line_step;
      end else begin
        x_r     <= cmd_r.fx;
        y_r     <= cmd_r.fy;
        z_r     <= z_r + 1'b1;
        plane_r <= plane_step;
        line_r  <= plane_step;
        idx_r   <= plane_step;
      end
    end
  end

  assign busy      = (state_r == SC_RUN);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `GCRE_ASSERT_IMPLY(a_count_cap, clk, rst_n, state_r == SC_RUN, n_r < CNT_W'(MAX_CELLS))
  `GCRE_ASSERT_IMPLY(a_start_idle, clk, rst_n, start, state_r == SC_IDLE)
  `GCRE_ASSERT_NEXT(a_start_busy, clk, rst_n, start, state_r == SC_RUN)
  `GCRE_ASSERT_IMPLY(a_end_last, clk, rst_n, $fell(state_r == SC_RUN), out_valid_r && out_data_r.last)
  `GCRE_ASSERT_IMPLY(a_empty_last, clk, rst_n, out_valid_r && out_data_r.range_empty, out_data_r.last)

endmodule

FILE: hw/rtl/grid_cell_range_enumerator_top.sv
// Flow: a box takes six divisions by the cell size on one shared restoring divider,
// then the clamp check and stride products before the first result; then one result per
// cycle unless out_stall holds it, up to 64 per box. Zero cell size: one result, no division.
// A new box is taken only after the scan of the previous box has finished.
// Reset: synchronous, active low; clears the control state and the config registers to zero.
module grid_cell_range_enumerator_top
  import gcre_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [GRID_W-1:0]     cfg_data
);

  top_st_t                  state_r;
  top_st_t                  state_nxt;
  logic [SIZE_W-1:0]        cell_size_r;
  logic [GRID_W-1:0]        grid_low_r;
  logic [GRID_W-1:0]        grid_high_r;
  logic [SIZE_W-1:0]        row_stride_r;
  logic [SIZE_W-1:0]        plane_stride_r;
  in_t                      box_r;
  logic [2:0]               k_r;
  logic signed [CELL_W-1:0] cell_r [6];
  logic [SAT_W-1:0]         dz_sat_r;
  logic [PROD2_W-1:0]       dxy_r;
  logic [IDX_W-1:0]         prod_z_r;
  logic [IDX_W-1:0]         prod_y_r;
  logic                     trunc_r;
  logic                     single_r;
  logic                     empty_r;

  logic                     accept;
  logic                     div_start;
  logic                     div_done;
  logic [COORD_W-1:0]       div_q;
  logic signed [COORD_W-1:0] coord;
  logic [COORD_W-1:0]       coord_mag;
  logic [1:0]               axis;
  logic signed [QUOT_W-1:0] lo_ext;
  logic signed [QUOT_W-1:0] hi_ext;
  logic signed [QUOT_W-1:0] q_cell;
  logic signed [QUOT_W-1:0] c_lo;
  logic signed [QUOT_W-1:0] c_hi;
  logic signed [QUOT_W-1:0] c_reb;
  logic signed [DIM_W-1:0]  dim [3];
  logic [SAT_W-1:0]         dim_sat [3];
  logic                     any_empty;
  logic [PROD3_W-1:0]       total;
  logic [IDX_W-1:0]         fx_ext;
  logic [IDX_W-1:0]         fy_ext;
  logic [IDX_W-1:0]         fz_ext;
  logic                     scan_start;
  logic                     scan_busy;
  scan_cmd_t                cmd;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r    <= '0;
      grid_low_r     <= '0;
      grid_high_r    <= '0;
      row_stride_r   <= '0;
      plane_stride_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        CFG_CELL_SIZE:    cell_size_r    <= cfg_data[SIZE_W-1:0];
        CFG_GRID_LOW:     grid_low_r     <= cfg_data;
        CFG_GRID_HIGH:    grid_high_r    <= cfg_data;
        CFG_ROW_STRIDE:   row_stride_r   <= cfg_data[SIZE_W-1:0];
        CFG_PLANE_STRIDE: plane_stride_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (k_r)
      3'd0:    coord = box_r.box_low_x;
      3'd1:    coord = box_r.box_low_y;
      3'd2:    coord = box_r.box_low_z;
      3'd3:    coord = box_r.box_high_x;
      3'd4:    coord = box_r.box_high_y;
      default: coord = box_r.box_high_z;
    endcase
    axis      = (k_r < 3'd3) ? k_r[1:0] : 2'(k_r - 3'd3);
    coord_mag = coord[COORD_W-1] ? COORD_W'(-coord) : COORD_W'(coord);
    lo_ext    = QUOT_W'($signed(grid_low_r[axis*BOUND_W +: BOUND_W]));
    hi_ext    = QUOT_W'($signed(grid_high_r[axis*BOUND_W +: BOUND_W]));
    // negative coordinates floor one further: -(q) - 1 == ~q
    q_cell    = coord[COORD_W-1] ? ~$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    c_lo      = (q_cell < lo_ext) ? lo_ext : q_cell;
    c_hi      = (hi_ext < c_lo) ? hi_ext : c_lo;
    c_reb     = c_hi - lo_ext;
  end

  always_comb begin
    any_empty = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dim[i]     = DIM_W'(cell_r[i+3]) - DIM_W'(cell_r[i]) + DIM_W'(1);
      dim_sat[i] = (dim[i] > DIM_W'(MAX_CELLS)) ? SAT_W'(MAX_CELLS + 1) : dim[i][SAT_W-1:0];
      if (cell_r[i] > cell_r[i+3]) any_empty = 1'b1;
    end
    total  = PROD3_W'(dxy_r) * PROD3_W'(dz_sat_r);
    fx_ext = IDX_W'(cell_r[0]);
    fy_ext = IDX_W'(cell_r[1]);
    fz_ext = IDX_W'(cell_r[2]);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = (cell_size_r == '0) ? ST_LAUNCH : ST_DLOAD;
      ST_DLOAD:  state_nxt = ST_DWAIT;
      ST_DWAIT:  if (div_done) state_nxt = (k_r == 3'd5) ? ST_CHECK : ST_DLOAD;
      ST_CHECK:  state_nxt = any_empty ? ST_LAUNCH : ST_MUL;
      ST_MUL:    state_nxt = ST_LAUNCH;
      ST_LAUNCH: state_nxt = ST_WAIT;
      ST_WAIT:   if (!scan_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    div_start  = (state_r == ST_DLOAD);
    scan_start = (state_r == ST_LAUNCH);
    cmd.single = single_r;
    cmd.empty  = empty_r;
    cmd.trunc  = trunc_r;
    cmd.fx     = cell_r[0];
    cmd.fy     = cell_r[1];
    cmd.fz     = cell_r[2];
    cmd.sx     = cell_r[3];
    cmd.sy     = cell_r[4];
    cmd.sz     = cell_r[5];
    cmd.base   = prod_z_r + prod_y_r + fx_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        box_r    <= in_data;
        k_r      <= '0;
        single_r <= (cell_size_r == '0);
        empty_r  <= 1'b0;
        trunc_r  <= 1'b0;
      end
      ST_DWAIT: begin
        if (div_done) begin
          cell_r[k_r] <= CELL_W'(c_reb);
          k_r         <= k_r + 1'b1;
        end
      end
      ST_CHECK: begin
        single_r <= any_empty;
        empty_r  <= any_empty;
        dxy_r    <= PROD2_W'(dim_sat[0]) * PROD2_W'(dim_sat[1]);
        dz_sat_r <= dim_sat[2];
        prod_z_r <= IDX_W'(plane_stride_r) * fz_ext;
      end
      ST_MUL: begin
        trunc_r  <= (total > PROD3_W'(MAX_CELLS));
        prod_y_r <= IDX_W'(row_stride_r) * fy_ext;
      end
      default: ;
    endcase
  end

  gcre_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (coord_mag),
    .divisor  (cell_size_r),
    .done     (div_done),
    .quotient (div_q)
  );

  gcre_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (scan_start),
    .cmd          (cmd),
    .row_stride   (row_stride_r),
    .plane_stride (plane_stride_r),
    .busy         (scan_busy),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .out_stall    (out_stall)
  );

endmodule

FILE: tb/tb_top.sv
module tb_top;
  import gcre_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 600;
  localparam int DRAIN_CYCLES   = 200;
  localparam int SETTLE_CYCLES  = 8;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [GRID_W-1:0]     cfg_data  = '0;

  grid_cell_range_enumerator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's registers
  logic [SIZE_W-1:0] cell_size_q    = '0;
  logic [GRID_W-1:0] grid_low_q     = '0;
  logic [GRID_W-1:0] grid_high_q    = '0;
  logic [SIZE_W-1:0] row_stride_q   = '0;
  logic [SIZE_W-1:0] plane_stride_q = '0;

  in_t  box_q[$];
  out_t pending_cells[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int err_cnt     = 0;
  int res_cnt     = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  int idle_cycles = 0;

  function automatic int cell_of(int coord, int size, int lo, int hi);
    int c;
    c = coord / size;
    if (coord < 0) c -= 1;
    if (c < lo) c = lo;
    if (hi < c) c = hi;
    return c - lo;
  endfunction

  function automatic void enumerate_cells(in_t box);
    int          corner_lo[3];
    int          corner_hi[3];
    int          first[3];
    int          second[3];
    int          size, lo, hi, n, x, y, z;
    longint      total;
    longint      n_emit;
    bit          trunc;
    out_t        r;
    if (cell_size_q == 0) begin
      r = '{cell_index: '0, range_empty: 1'b0, truncated: 1'b0, last: 1'b1};
      pending_cells.push_back(r);
      return;
    end
    corner_lo[0] = $signed(box.box_low_x);
    corner_lo[1] = $signed(box.box_low_y);
    corner_lo[2] = $signed(box.box_low_z);
    corner_hi[0] = $signed(box.box_high_x);
    corner_hi[1] = $signed(box.box_high_y);
    corner_hi[2] = $signed(box.box_high_z);
    size  = int'(cell_size_q);
    total = 1;
    for (int a = 0; a < 3; a++) begin
      lo = int'($signed(grid_low_q[BOUND_W*a +: BOUND_W]));
      hi = int'($signed(grid_high_q[BOUND_W*a +: BOUND_W]));
      first[a]  = cell_of(corner_lo[a], size, lo, hi);
      second[a] = cell_of(corner_hi[a], size, lo, hi);
      if (first[a] > second[a]) begin
        r = '{cell_index: '0, range_empty: 1'b1, truncated: 1'b0, last: 1'b1};
        pending_cells.push_back(r);
        return;
      end
      total *= longint'(second[a]) - longint'(first[a]) + 1;
    end
    trunc  = total > MAX_CELLS;
    n_emit = trunc ? MAX_CELLS : total;
    n = 0;
    for (z = first[2]; z <= second[2] && n < MAX_CELLS; z++) begin
      for (y = first[1]; y <= second[1] && n < MAX_CELLS; y++) begin
        for (x = first[0]; x <= second[0] && n < MAX_CELLS; x++) begin
          r.cell_index  = plane_stride_q * $unsigned(z) + row_stride_q * $unsigned(y)
                        + $unsigned(x);
          r.range_empty = 1'b0;
          r.truncated   = trunc;
          r.last        = (n == n_emit - 1);
          pending_cells.push_back(r);
          n++;
        end
      end
    end
  endfunction

  function automatic logic [GRID_W-1:0] pack3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic in_t make_box(int lx, int ly, int lz, int hx, int hy, int hz);
    in_t b;
    b.box_low_x  = 24'(lx);
    b.box_low_y  = 24'(ly);
    b.box_low_z  = 24'(lz);
    b.box_high_x = 24'(hx);
    b.box_high_y = 24'(hy);
    b.box_high_z = 24'(hz);
    return b;
  endfunction

  function automatic int clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return int'(v);
  endfunction

  // mostly boxes of a few cells around the grid's low corner; some noise and swapped corners
  function automatic in_t random_box();
    int     lc[3];
    int     hc[3];
    int     size, base, w, kind, swap_axis, t;
    in_t    b;
    kind      = $urandom_range(99);
    swap_axis = $urandom_range(2);
    if (kind < 15) begin
      b = in_t'({$urandom, $urandom, $urandom, $urandom, 16'($urandom)});
      return b;
    end
    size = (cell_size_q == 0) ? 1 : int'(cell_size_q);
    for (int a = 0; a < 3; a++) begin
      base  = int'($signed(grid_low_q[BOUND_W*a +: BOUND_W])) + int'($urandom_range(0, 7)) - 1;
      w     = $urandom_range(0, 3);
      lc[a] = clamp24(longint'(base) * size + $urandom_range(0, size - 1));
      hc[a] = clamp24(longint'(base + w) * size + $urandom_range(0, size - 1));
      if (kind >= 88 && a == swap_axis) begin
        t     = lc[a];
        lc[a] = hc[a];
        hc[a] = t;
      end
    end
    return make_box(lc[0], lc[1], lc[2], hc[0], hc[1], hc[2]);
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [GRID_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (addr)
      CFG_CELL_SIZE:    cell_size_q    = data[SIZE_W-1:0];
      CFG_GRID_LOW:     grid_low_q     = data;
      CFG_GRID_HIGH:    grid_high_q    = data;
      CFG_ROW_STRIDE:   row_stride_q   = data[SIZE_W-1:0];
      CFG_PLANE_STRIDE: plane_stride_q = data[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(int size, logic [GRID_W-1:0] lo, logic [GRID_W-1:0] hi,
                           int row, int plane);
    write_reg(CFG_CELL_SIZE, GRID_W'(size));
    write_reg(CFG_GRID_LOW, lo);
    write_reg(CFG_GRID_HIGH, hi);
    write_reg(CFG_ROW_STRIDE, GRID_W'(row));
    write_reg(CFG_PLANE_STRIDE, GRID_W'(plane));
  endtask

  task automatic random_config();
    int lo[3];
    int hi[3];
    int r, size, row, plane;
    logic [GRID_W-1:0] lo_w, hi_w;
    r    = $urandom_range(9);
    size = (r == 0) ? 0 : (r == 1) ? 32767 : $urandom_range(1, 40);
    if ($urandom_range(5) == 0) begin
      lo_w = GRID_W'({$urandom, $urandom});
      hi_w = GRID_W'({$urandom, $urandom});
    end else begin
      for (int a = 0; a < 3; a++) begin
        lo[a] = 0 - int'($urandom_range(0, 6));
        hi[a] = lo[a] + int'($urandom_range(0, 8));
      end
      lo_w = pack3(lo[0], lo[1], lo[2]);
      hi_w = pack3(hi[0], hi[1], hi[2]);
    end
    if ($urandom_range(3) == 0) begin
      row   = $urandom_range(0, 32767);
      plane = $urandom_range(0, 32767);
    end else begin
      row   = $urandom_range(1, 12);
      plane = row * int'($urandom_range(1, 12));
    end
    write_all(size, lo_w, hi_w, row, plane);
  endtask

  task automatic wait_idle();
    while (box_q.size() != 0 || in_valid || pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) enumerate_cells(in_data);
      if (!(in_valid && in_stall)) begin
        if (box_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= box_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        res_cnt++;
        if (pending_cells.size() == 0) begin
          $error("unexpected transaction: %h", out_data);
          err_cnt++;
        end else begin
          want = pending_cells.pop_front();
          if (out_data.cell_index !== want.cell_index) begin
            $error("cell_index: expected %0h, got %0h", want.cell_index, out_data.cell_index);
            err_cnt++;
          end
          if (out_data.range_empty !== want.range_empty) begin
            $error("range_empty: expected %0b, got %0b", want.range_empty, out_data.range_empty);
            err_cnt++;
          end
          if (out_data.truncated !== want.truncated) begin
            $error("truncated: expected %0b, got %0b", want.truncated, out_data.truncated);
            err_cnt++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data.last);
            err_cnt++;
          end
        end
      end
      // one long hold-off while boxes are still queued
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && res_cnt > 150 && box_q.size() > 4) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      out_stall <= (hold_left > 0) || ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 32;
    rx_idle_pct = 77;

    // registers at reset: zero cell size
    box_q.push_back(make_box(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    box_q.push_back(make_box(8388607, 8388607, 8388607, -8388608, -8388608, -8388608));
    wait_idle();

    write_all(10, pack3(-5, -5, -5), pack3(5, 5, 5), 11, 121);
    box_q.push_back(make_box(0, 0, 0, 0, 0, 0));
    box_q.push_back(make_box(-10, -10, -10, -1, -1, -1));
    box_q.push_back(make_box(-1, -1, -1, 0, 0, 0));
    box_q.push_back(make_box(5, 5, 5, -5, -5, -5));
    box_q.push_back(make_box(0, 0, 0, 49, 9, 9));
    box_q.push_back(make_box(0, 0, 0, 39, 39, 39));
    box_q.push_back(make_box(0, 0, 0, 49, 39, 39));
    box_q.push_back(make_box(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    box_q.push_back(make_box(8388607, 8388607, 8388607, -8388608, -8388608, -8388608));
    box_q.push_back(make_box(-8388608, 0, 0, -8388608, 0, 0));
    box_q.push_back(make_box(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    wait_idle();

    // low bound above high bound
    write_all(3, pack3(3, 3, 3), pack3(1, 1, 1), 7, 50);
    box_q.push_back(make_box(0, 0, 0, 5, 5, 5));
    box_q.push_back(make_box(5, 5, 5, 0, 0, 0));
    box_q.push_back(make_box(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    wait_idle();

    write_all(32767, pack3(-32768, -32768, -32768), pack3(32767, 32767, 32767), 32767, 32767);
    box_q.push_back(make_box(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    box_q.push_back(make_box(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    box_q.push_back(make_box(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608));
    wait_idle();

    write_reg(CFG_CELL_SIZE, GRID_W'(1));
    write_reg(CFG_ROW_STRIDE, '0);
    write_reg(CFG_PLANE_STRIDE, '0);
    write_reg(CFG_UNUSED_IDX, '1);
    box_q.push_back(make_box(0, 0, 0, 1, 1, 1));
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        tx_idle_pct = 77;
        rx_idle_pct = 32;
      end else if (ph == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_config();
      repeat (27) box_q.push_back(random_box());
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending_cells.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
